// File: hdl/rwv_pkg.sv
`default_nettype none
package rwv_pkg;

    // Field widths
    localparam int PosW   = 24;
    localparam int DiffW  = 25;
    localparam int VelW   = 16;
    localparam int LevelW = 8;
    localparam int SpeedW = 15;
    localparam int DistW  = 25;
    localparam int ProdW  = 50;
    localparam int FullW  = 33;
    localparam int MnW    = 48;
    localparam int RemW   = 50;
    localparam int DshW   = 51;
    localparam int QW     = 18;
    localparam int RootW  = 28;

    // Iteration counts
    localparam int RootSteps = 25;
    localparam int DivSteps  = 18;

    // Shared multiplier operand selects
    localparam logic [2:0] MUL_SQ_X   = 3'd0;
    localparam logic [2:0] MUL_SQ_Y   = 3'd1;
    localparam logic [2:0] MUL_SQ_Z   = 3'd2;
    localparam logic [2:0] MUL_NUM    = 3'd3;
    localparam logic [2:0] MUL_FULL   = 3'd4;
    localparam logic [2:0] MUL_MN_X   = 3'd5;
    localparam logic [2:0] MUL_MN_Y   = 3'd6;
    localparam logic [2:0] MUL_MN_Z   = 3'd7;

    // Register indexes
    localparam logic [2:0] REG_RAMPED_MODE   = 3'd0;
    localparam logic [2:0] REG_CRUISE_SPEED  = 3'd1;
    localparam logic [2:0] REG_RAMP_STEPS    = 3'd2;
    localparam logic [2:0] REG_SLOW_RADIUS   = 3'd3;
    localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd4;

    typedef struct packed {
        logic              ramped_mode;
        logic [SpeedW-1:0] cruise_speed;
        logic [7:0]        ramp_steps;
        logic [PosW-1:0]   slow_radius;
        logic [PosW-1:0]   arrive_radius;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       root_init;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       commit;
    } cmd_t;

endpackage
`default_nettype wire

// File: hdl/rwv_ctrl.sv
`default_nettype none
module rwv_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    input  wire                out_free,
    output logic               in_ready,
    output rwv_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SQ        = 3'd1;
    localparam logic [2:0] ST_ROOT_INIT = 3'd2;
    localparam logic [2:0] ST_ROOT      = 3'd3;
    localparam logic [2:0] ST_MUL       = 3'd4;
    localparam logic [2:0] ST_DIV_INIT  = 3'd5;
    localparam logic [2:0] ST_DIV       = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencing of the shared multiplier, root and divider steps.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ;
                    cnt_next   = '0;
                end
            end
            ST_SQ: begin
                // Three squares, then a wait state so that the last product reaches the sum.
                cmd.mul_en  = (cnt_reg < 5'd3);
                cmd.mul_sel = cnt_reg[2:0];
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3) begin
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT: begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'(rwv_pkg::RootSteps - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en  = (cnt_reg < 5'd5);
                cmd.mul_sel = 3'(cnt_reg + 5'd3);
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'd5) begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(rwv_pkg::DivSteps - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/rwv_datapath.sv
`default_nettype none
module rwv_datapath (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  rwv_pkg::cmd_t                         cmd,
    input  rwv_pkg::cfg_t                         cfg,
    input  wire [6*rwv_pkg::PosW-1:0]             in_data,
    output logic [3*rwv_pkg::VelW-1:0]            vel,
    output logic                                  arrived,
    output logic [rwv_pkg::LevelW-1:0]            ramp_now
);

    localparam int PW = rwv_pkg::PosW;

    logic [rwv_pkg::DiffW-1:0]  mag_reg [3];
    logic                       neg_reg [3];
    logic [rwv_pkg::ProdW-1:0]  prod_reg;
    logic [2:0]                 prod_sel_reg;
    logic                       prod_vld_reg;
    logic [rwv_pkg::ProdW-1:0]  acc_reg;
    logic [rwv_pkg::ProdW-1:0]  sx_reg;
    logic [rwv_pkg::RootW-1:0]  rem_reg;
    logic [rwv_pkg::DistW-1:0]  root_reg;
    logic [22:0]                num_reg;
    logic [rwv_pkg::FullW-1:0]  full_reg;
    logic [rwv_pkg::MnW-1:0]    mn_reg [3];
    logic [rwv_pkg::RemW-1:0]   r_reg [3];
    logic [rwv_pkg::DshW-1:0]   dsh_reg;
    logic [rwv_pkg::QW-1:0]     q_reg [3];
    logic [rwv_pkg::LevelW-1:0] level_reg, level_next;

    logic [7:0]                 steps;
    logic [7:0]                 den;
    logic                       arr;
    logic                       far;
    logic [rwv_pkg::DiffW-1:0]  mul_a, mul_b;
    logic [rwv_pkg::RootW-1:0]  rem_sh, trial;

    assign steps = (cfg.ramp_steps == 8'd0) ? 8'd1 : cfg.ramp_steps;
    assign den   = cfg.ramped_mode ? steps : 8'd1;
    assign arr   = (root_reg < {1'b0, cfg.arrive_radius});
    assign far   = (root_reg >= {1'b0, cfg.slow_radius});

    // Per-axis difference, kept as sign and magnitude.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [rwv_pkg::DiffW-1:0] df;
                df = $signed({in_data[(i+3)*PW+PW-1], in_data[(i+3)*PW +: PW]})
                   - $signed({in_data[i*PW+PW-1], in_data[i*PW +: PW]});
                neg_reg[i] <= df[rwv_pkg::DiffW-1];
                mag_reg[i] <= df[rwv_pkg::DiffW-1] ? 25'(-df) : 25'(df);
            end
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            rwv_pkg::MUL_SQ_X: begin mul_a = mag_reg[0]; mul_b = mag_reg[0]; end
            rwv_pkg::MUL_SQ_Y: begin mul_a = mag_reg[1]; mul_b = mag_reg[1]; end
            rwv_pkg::MUL_SQ_Z: begin mul_a = mag_reg[2]; mul_b = mag_reg[2]; end
            rwv_pkg::MUL_NUM: begin
                mul_a = 25'(cfg.cruise_speed);
                mul_b = 25'(level_reg);
            end
            rwv_pkg::MUL_FULL: begin mul_a = root_reg; mul_b = 25'(den); end
            rwv_pkg::MUL_MN_X: begin mul_a = mag_reg[0]; mul_b = 25'(num_reg); end
            rwv_pkg::MUL_MN_Y: begin mul_a = mag_reg[1]; mul_b = 25'(num_reg); end
            rwv_pkg::MUL_MN_Z: begin mul_a = mag_reg[2]; mul_b = 25'(num_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Product register, then the product lands where its select says.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
        end
        prod_reg     <= mul_a * mul_b;
        prod_sel_reg <= cmd.mul_sel;
        if (cmd.load) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            case (prod_sel_reg)
                rwv_pkg::MUL_SQ_X, rwv_pkg::MUL_SQ_Y, rwv_pkg::MUL_SQ_Z: begin
                    acc_reg <= acc_reg + prod_reg;
                end
                rwv_pkg::MUL_NUM: begin
                    if (cfg.ramped_mode) begin
                        num_reg <= prod_reg[22:0];
                    end else begin
                        num_reg <= arr ? 23'd0 : 23'(cfg.cruise_speed);
                    end
                end
                rwv_pkg::MUL_FULL: full_reg <= prod_reg[rwv_pkg::FullW-1:0];
                rwv_pkg::MUL_MN_X: mn_reg[0] <= prod_reg[rwv_pkg::MnW-1:0];
                rwv_pkg::MUL_MN_Y: mn_reg[1] <= prod_reg[rwv_pkg::MnW-1:0];
                rwv_pkg::MUL_MN_Z: mn_reg[2] <= prod_reg[rwv_pkg::MnW-1:0];
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    // Digit-by-digit square root, one result bit per cycle.
    assign rem_sh = {rem_reg[25:0], sx_reg[rwv_pkg::ProdW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.root_init) begin
            sx_reg   <= acc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            sx_reg <= {sx_reg[rwv_pkg::ProdW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[23:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[23:0], 1'b0};
            end
        end
    end

    // Three restoring dividers in parallel, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dsh_reg <= {full_reg, 18'd0};
            for (int i = 0; i < 3; i++) begin
                r_reg[i] <= {1'b0, mn_reg[i], 1'b0} + 50'(full_reg);
                q_reg[i] <= '0;
            end
        end else if (cmd.div_step) begin
            dsh_reg <= {1'b0, dsh_reg[rwv_pkg::DshW-1:1]};
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, r_reg[i]} >= dsh_reg) begin
                    r_reg[i] <= 50'({1'b0, r_reg[i]} - dsh_reg);
                    q_reg[i] <= {q_reg[i][rwv_pkg::QW-2:0], 1'b1};
                end else begin
                    q_reg[i] <= {q_reg[i][rwv_pkg::QW-2:0], 1'b0};
                end
            end
        end
    end

    // Sign, rounding saturation and the zero-distance case.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [15:0] v;
            if (root_reg == '0) begin
                v = '0;
            end else if (neg_reg[i]) begin
                if (q_reg[i][17:16] != 2'b00 || (q_reg[i][15] && q_reg[i][14:0] != '0)) begin
                    v = 16'h8000;
                end else begin
                    v = 16'(17'h10000 - {1'b0, q_reg[i][15:0]});
                end
            end else if (q_reg[i][17:15] != 3'b000) begin
                v = 16'h7FFF;
            end else begin
                v = q_reg[i][15:0];
            end
            vel[i*rwv_pkg::VelW +: rwv_pkg::VelW] = v;
        end
    end

    // Ramp level update.
    always_comb begin
        level_next = level_reg;
        if (cfg.ramped_mode) begin
            if (far) begin
                if (level_reg < steps) begin
                    level_next = level_reg + 8'd1;
                end
            end else if (level_reg != 8'd0) begin
                level_next = level_reg - 8'd1;
            end
            if (arr) begin
                level_next = '0;
            end
        end
    end

    assign arrived  = arr;
    assign ramp_now = level_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 8'd1;
        end else if (cmd.commit) begin
            level_reg <= level_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ramped_waypoint_velocity_unit.sv
`default_nettype none
// Ramped waypoint velocity unit.
// An item on the s_ stream carries current and target positions (Q15.8). For
// each item one result item leaves on the m_ stream: the velocity command
// (Q1.14, saturated), the arrival flag and the ramp level after the update.
// Settings are to be written through the APB port only while the unit is idle;
// the unit itself does not enforce this. One item is in work at a time; it
// passes the 25-step square root and the 18-step dividers, which share one
// sequence with the 25x25 multiplier.
// A new item is taken as soon as the previous result has been moved to the
// output register, so a waiting result does not stop the next item.
// If the receiver stalls, the finished result waits inside until the output
// register frees; s_tready stays low meanwhile.
// Reset (aresetn low, synchronous) clears both streams, restores the
// register defaults and sets the ramp level to one.
module ramped_waypoint_velocity_unit (
    input  wire         aclk,
    input  wire         aresetn,
    // current_x, current_y, current_z, target_x, target_y, target_z
    input  wire [143:0] s_tdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // vel_x, vel_y, vel_z, arrived, ramp_now, 7 zero bits
    output logic [63:0] m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rwv_pkg::cfg_t cfg_reg;
    rwv_pkg::cmd_t cmd;
    logic          out_free;
    logic          m_tvalid_reg;
    logic [63:0]   m_tdata_reg;
    logic [47:0]   vel;
    logic          arrived;
    logic [7:0]    ramp_now;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramped_mode   <= 1'b1;
            cfg_reg.cruise_speed  <= 15'd16384;
            cfg_reg.ramp_steps    <= 8'd50;
            cfg_reg.slow_radius   <= 24'd768;
            cfg_reg.arrive_radius <= 24'd256;
        end else if (psel && penable && pwrite) begin
            case (idx)
                rwv_pkg::REG_RAMPED_MODE:   cfg_reg.ramped_mode   <= pwdata[0];
                rwv_pkg::REG_CRUISE_SPEED:  cfg_reg.cruise_speed  <= pwdata[14:0];
                rwv_pkg::REG_RAMP_STEPS:    cfg_reg.ramp_steps    <= pwdata[7:0];
                rwv_pkg::REG_SLOW_RADIUS:   cfg_reg.slow_radius   <= pwdata[23:0];
                rwv_pkg::REG_ARRIVE_RADIUS: cfg_reg.arrive_radius <= pwdata[23:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (idx)
            rwv_pkg::REG_RAMPED_MODE:   prdata = 32'(cfg_reg.ramped_mode);
            rwv_pkg::REG_CRUISE_SPEED:  prdata = 32'(cfg_reg.cruise_speed);
            rwv_pkg::REG_RAMP_STEPS:    prdata = 32'(cfg_reg.ramp_steps);
            rwv_pkg::REG_SLOW_RADIUS:   prdata = 32'(cfg_reg.slow_radius);
            rwv_pkg::REG_ARRIVE_RADIUS: prdata = 32'(cfg_reg.arrive_radius);
            default:                    prdata = '0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    rwv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    rwv_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .vel      (vel),
        .arrived  (arrived),
        .ramp_now (ramp_now)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.commit) begin
            m_tdata_reg <= {7'd0, ramp_now, arrived, vel};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// File: dv/tb_ramped_waypoint_velocity_unit.sv
`default_nettype none

// Predicts velocity commands and checks them against the unit's output.
class velocity_scoreboard;
    logic [63:0] pending[$];
    int          mismatches;
    int          checked;
    bit          ramped;
    logic [14:0] cruise;
    logic [7:0]  steps;
    logic [23:0] slow_rad;
    logic [23:0] arrive_rad;
    logic [7:0]  level;

    function new();
        ramped     = 1'b1;
        cruise     = 15'd16384;
        steps      = 8'd50;
        slow_rad   = 24'd768;
        arrive_rad = 24'd256;
        level      = 8'd1;
        mismatches = 0;
        checked    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            rwv_pkg::REG_RAMPED_MODE:   ramped = val[0];
            rwv_pkg::REG_CRUISE_SPEED:  cruise = val[14:0];
            rwv_pkg::REG_RAMP_STEPS:    steps = val[7:0];
            rwv_pkg::REG_SLOW_RADIUS:   slow_rad = val[23:0];
            rwv_pkg::REG_ARRIVE_RADIUS: arrive_rad = val[23:0];
            default: ;
        endcase
    endfunction

    // Bitwise integer square root, floor.
    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function logic [15:0] axis_speed(longint df, longint unsigned d,
                                     longint unsigned num, longint unsigned den);
        longint unsigned mag;
        longint unsigned full;
        longint unsigned q;
        if (d == 0 || den == 0) return 16'd0;
        mag = (df < 0) ? -df : df;
        full = d * den;
        q = (2 * mag * num + full) / (2 * full);
        if (df < 0) begin
            if (q > 32768) q = 32768;
            return 16'(17'h10000 - q);
        end
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    // Works out the result for one accepted position item.
    function void note_position(logic [143:0] data);
        longint          df[3];
        longint unsigned sum;
        longint unsigned d;
        longint unsigned num;
        longint unsigned den;
        logic [7:0]      stp;
        bit              arr;
        logic [63:0]     res;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            df[i] = longint'($signed(data[(3+i)*24 +: 24])) -
                    longint'($signed(data[i*24 +: 24]));
            sum += df[i] * df[i];
        end
        d = int_sqrt(sum);
        arr = d < arrive_rad;
        stp = (steps == 0) ? 8'd1 : steps;
        if (ramped) begin
            num = cruise * level;
            den = stp;
            if (d >= slow_rad) begin
                if (level < stp) level++;
            end else if (level > 0) begin
                level--;
            end
            if (arr) level = 0;
        end else begin
            num = arr ? 0 : cruise;
            den = 1;
        end
        res = '0;
        for (int i = 0; i < 3; i++) res[i*16 +: 16] = axis_speed(df[i], d, num, den);
        res[48] = arr;
        res[56:49] = level;
        pending = {pending, res};
    endfunction

    function void check_velocity(logic [63:0] got);
        logic [63:0] exp_v;
        checked++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            mismatches++;
            return;
        end
        exp_v = pending.pop_front();
        for (int i = 0; i < 3; i++)
            if (got[i*16 +: 16] !== exp_v[i*16 +: 16]) begin
                $display("%0t: vel axis %0d expected %h actual %h", $time, i,
                         exp_v[i*16 +: 16], got[i*16 +: 16]);
                mismatches++;
            end
        if (got[48] !== exp_v[48]) begin
            $display("%0t: arrived expected %b actual %b", $time, exp_v[48], got[48]);
            mismatches++;
        end
        if (got[56:49] !== exp_v[56:49]) begin
            $display("%0t: ramp_now expected %0d actual %0d", $time,
                     exp_v[56:49], got[56:49]);
            mismatches++;
        end
        if (got[63:57] !== 7'd0) begin
            $display("%0t: pad bits expected 0 actual %h", $time, got[63:57]);
            mismatches++;
        end
    endfunction
endclass

module tb_ramped_waypoint_velocity_unit;

    // An index with no register behind it.
    localparam logic [2:0] RegUnused = 3'd5;

    logic         aclk;
    logic         aresetn;
    logic [143:0] s_tdata;
    logic         s_tvalid;
    wire          s_tready;
    wire  [63:0]  m_tdata;
    wire          m_tvalid;
    logic         m_tready;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    wire  [31:0]  prdata;
    wire          pready;

    velocity_scoreboard board;
    int  idle_count;
    int  sent;

    ramped_waypoint_velocity_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: random stall before each result, with stall-free stretches.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            board.check_velocity(m_tdata);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        wait (idle_count >= 20000);
        $display("ramped_waypoint_velocity_unit test failed");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_position(logic [143:0] data);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= data;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_position(data);
        sent++;
    endtask

    // Target placed at a random offset from current; span picks the distance scale.
    function automatic logic [143:0] near_item(int span);
        logic [143:0] v;
        logic [23:0]  c;
        for (int i = 0; i < 3; i++) begin
            c = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
            if ($urandom_range(0, 1)) c = -c;
            v[i*24 +: 24] = c;
            v[(3+i)*24 +: 24] = c + 24'($signed($urandom_range(0, 2*span)) - span);
        end
        return v;
    endfunction

    function automatic logic [143:0] raw_item();
        logic [143:0] v;
        for (int i = 0; i < 6; i++) v[i*24 +: 24] = 24'($urandom_range(0, 24'hFFFFFF));
        return v;
    endfunction

    // Wait until all results are back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) send_position(near_item(400));
            else if (pick < 6) send_position(near_item(4000));
            else if (pick < 8) send_position(near_item(200000));
            else send_position(raw_item());
        end
    endtask

    initial begin
        logic [143:0] v;
        board = new();
        aresetn = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero distance, extremes, slow and arrive bands, ramp climb.
        send_position('0);
        v = '0;
        v[71:0] = {3{24'h800000}};
        v[143:72] = {3{24'h7FFFFF}};
        send_position(v);
        send_position({v[71:0], v[143:72]});
        v = '0;
        v[95:72] = 24'd100;
        send_position(v);
        v[95:72] = 24'd500;
        send_position(v);
        v = '0;
        v[119:96] = 24'hFFFC00;
        for (int i = 0; i < 8; i++) send_position(v);
        v[143:120] = 24'd255;
        v[119:96] = 24'd0;
        send_position(v);
        v[143:120] = 24'd256;
        send_position(v);
        drain();

        // Ramp steps lowered to 2 and reached by far items, then the zero-step case.
        write_reg(rwv_pkg::REG_RAMP_STEPS, 32'd2);
        write_reg(rwv_pkg::REG_CRUISE_SPEED, 32'h7FFF);
        v = '0;
        v[95:72] = 24'd5000;
        send_position(v);
        send_position(v);
        drain();
        write_reg(rwv_pkg::REG_RAMP_STEPS, 32'd0);
        send_position(v);
        send_position(v);
        drain();

        // Default settings, then a series of other settings.
        write_reg(rwv_pkg::REG_RAMP_STEPS, 32'd50);
        write_reg(rwv_pkg::REG_CRUISE_SPEED, 32'd16384);
        random_phase(150);
        drain();
        write_reg(rwv_pkg::REG_RAMPED_MODE, 32'd0);
        write_reg(rwv_pkg::REG_ARRIVE_RADIUS, 32'd2000);
        random_phase(150);
        drain();
        write_reg(rwv_pkg::REG_ARRIVE_RADIUS, 32'h00FFFFFF);
        write_reg(rwv_pkg::REG_CRUISE_SPEED, 32'h7FFF);
        random_phase(60);
        drain();
        write_reg(rwv_pkg::REG_ARRIVE_RADIUS, 32'd0);
        write_reg(rwv_pkg::REG_SLOW_RADIUS, 32'd0);
        write_reg(rwv_pkg::REG_RAMPED_MODE, 32'd1);
        write_reg(rwv_pkg::REG_RAMP_STEPS, 32'd255);
        random_phase(150);
        drain();
        write_reg(rwv_pkg::REG_SLOW_RADIUS, 32'h00FFFFFF);
        write_reg(rwv_pkg::REG_ARRIVE_RADIUS, 32'd300);
        write_reg(rwv_pkg::REG_CRUISE_SPEED, 32'd0);
        random_phase(60);
        drain();
        write_reg(rwv_pkg::REG_SLOW_RADIUS, 32'd3000);
        write_reg(rwv_pkg::REG_RAMP_STEPS, 32'd1);
        write_reg(rwv_pkg::REG_CRUISE_SPEED, 32'd20000);
        random_phase(120);
        drain();
        write_reg(rwv_pkg::REG_RAMP_STEPS, 32'd17);
        write_reg(RegUnused, 32'hFFFFFFFF);
        random_phase(130);
        drain();

        $display("Covered %0d position items over several settings, %0d results checked.",
                 sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("ramped_waypoint_velocity_unit test passed");
        end else begin
            $display("ramped_waypoint_velocity_unit test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: ramped_waypoint_velocity_unit.f
hdl/rwv_pkg.sv
hdl/rwv_ctrl.sv
hdl/rwv_datapath.sv
hdl/ramped_waypoint_velocity_unit.sv
dv/tb_ramped_waypoint_velocity_unit.sv
